FILE: src/csma_ca_channel_access_top_defines.svh
// assertion macros for the channel access controller
// expects signals named clock and reset in the including module
`ifndef CSMA_CA_CHANNEL_ACCESS_TOP_DEFINES_SVH
`define CSMA_CA_CHANNEL_ACCESS_TOP_DEFINES_SVH

`ifndef SYNTH
`define CSMA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define CSMA_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define CSMA_ASSERT(label, prop, msg)
`define CSMA_ASSERT_RST(label, prop, msg)
`endif

`endif

FILE: src/csma_pkg.sv
// shared types, codes and constants of the channel access controller
// no dependencies
`default_nettype none

package csma_pkg;

   localparam int GUARD_TICKS = 5;
   localparam int DIV_W       = 16;
   localparam int DIV_CNT_W   = $clog2(DIV_W + 1);

   typedef logic [1:0]        command_type;
   typedef logic [14:0]       ticks_type;
   typedef logic [7:0]        length_type;
   typedef logic signed [8:0] dbm_type;
   typedef logic [31:0]       timer_type;
   typedef logic [15:0]       random_type;
   typedef logic [2:0]        action_type;
   typedef logic [1:0]        csr_index_type;
   typedef logic [8:0]        csr_data_type;

   localparam command_type CMD_START  = 2'd0;
   localparam command_type CMD_RSSI   = 2'd1;
   localparam command_type CMD_FINISH = 2'd2;

   localparam action_type ACT_NONE = 3'd0;
   localparam action_type ACT_WAIT = 3'd1;
   localparam action_type ACT_TX   = 3'd2;
   localparam action_type ACT_FAIL = 3'd3;
   localparam action_type ACT_DONE = 3'd4;

   localparam logic [1:0] MODE_UNCHECKED = 2'd0;
   localparam logic [1:0] MODE_FIXED     = 2'd1;
   localparam logic [1:0] MODE_RANDOM    = 2'd2;
   localparam logic [1:0] MODE_HALVING   = 2'd3;

   localparam logic [1:0] RC_LOW    = 2'd0;
   localparam logic [1:0] RC_NORMAL = 2'd1;
   localparam logic [1:0] RC_HIGH   = 2'd2;

   localparam csr_index_type REG_THRESHOLD = 2'd0;
   localparam csr_index_type REG_MODE      = 2'd1;
   localparam csr_index_type REG_RATE      = 2'd2;

   localparam dbm_type         THRESHOLD_RESET = -9'sd86;
   localparam ticks_type       CCA_GAP         = 15'd5;
   localparam logic [DIV_W-1:0] RATE_LOW       = 16'd1;
   localparam logic [DIV_W-1:0] RATE_NORMAL    = 16'd6;
   localparam logic [DIV_W-1:0] RATE_HIGH      = 16'd20;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_CCA1,
      PH_CCA2,
      PH_TX
   } phase_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_AIR,
      ST_BUSY,
      ST_OFFSET,
      ST_SLOTS,
      ST_MOD,
      ST_MUL,
      ST_ARM
   } state_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic             busy;
      logic [DIV_W-1:0] quotient;
      logic [DIV_W-1:0] remainder;
   } div_rsp_type;

endpackage

`default_nettype wire

FILE: src/csma_if.sv
// request and response channel interfaces of the channel access controller
// depends on csma_pkg
`default_nettype none

interface csma_req_if;
   import csma_pkg::*;

   logic        valid;
   logic        ready;
   command_type command;
   ticks_type   time_budget;
   length_type  frame_length;
   dbm_type     rssi_sample;
   timer_type   timer_now;
   random_type  random_word;

   modport source (
      output valid, command, time_budget, frame_length, rssi_sample, timer_now,
             random_word,
      input  ready
   );
   modport sink (
      input  valid, command, time_budget, frame_length, rssi_sample, timer_now,
             random_word,
      output ready
   );
endinterface

interface csma_rsp_if;
   import csma_pkg::*;

   logic       valid;
   logic       ready;
   action_type action;
   ticks_type  delay_ticks;
   logic       busy_res;

   modport source (
      output valid, action, delay_ticks, busy_res,
      input  ready
   );
   modport sink (
      input  valid, action, delay_ticks, busy_res,
      output ready
   );
endinterface

`default_nettype wire

FILE: src/csma_div.sv
// shared radix-2 restoring divider, one quotient bit per cycle
// depends on csma_pkg
`default_nettype none

module csma_div (
   input  logic                  clock,
   input  logic                  reset,
   input  csma_pkg::div_req_type div_req,
   output csma_pkg::div_rsp_type div_rsp
);
   import csma_pkg::*;

   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIV_W-1:0]     dsr_ff, dsr_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic                 done_ff, done_in;
   logic [DIV_W:0]       shifted;
   logic [DIV_W:0]       trial;

   always_comb begin
      shifted  = {rem_ff, quo_ff[DIV_W-1]};
      trial    = shifted - {1'b0, dsr_ff};
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dsr_in   = dsr_ff;
      count_in = count_ff;
      done_in  = 1'b0;
      if (div_req.start) begin
         rem_in   = '0;
         quo_in   = div_req.dividend;
         dsr_in   = div_req.divisor;
         count_in = DIV_CNT_W'(DIV_W);
      end else if (count_ff != '0) begin
         if (trial[DIV_W]) begin
            rem_in = shifted[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end else begin
            rem_in = trial[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end
         count_in = count_ff - 1'b1;
         done_in  = (count_ff == DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.busy      = (count_ff != '0);
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

`default_nettype wire

FILE: src/csma_ca_channel_access_top.sv
// top level of the csma-ca channel access controller: sequencer and state
// depends on csma_pkg, csma_if, csma_div and the assertion macro header
//
// Handles one request transfer at a time; req ready is low from acceptance until the
// response is stored in the output register, and also while a stored response has not been
// taken. Every division (air time, slot count, random pick modulo slot count or half slot)
// goes through one shared radix-2 divider. An rssi sample that finds the channel clear, a
// finish, or an ignored command is answered from the decode state. A start divides for air
// time, then by mode arms at once, draws a random slot or a random offset under the halved
// window; a busy sample checks the guard time, then does the same. Fixed slot mode starts
// with offset 0 and uses random slots on retries. There is no clearing pass after reset.
`default_nettype none
`include "csma_ca_channel_access_top_defines.svh"

module csma_ca_channel_access_top (
   input  logic                    clock,
   input  logic                    reset,
   csma_req_if.sink                req_ch,
   csma_rsp_if.source              rsp_ch,
   input  logic                    csr_we,
   input  csma_pkg::csr_index_type csr_index,
   input  csma_pkg::csr_data_type  csr_wdata
);
   import csma_pkg::*;

   // configuration
   dbm_type     thr_ff;
   logic [1:0]  mode_ff;
   logic [1:0]  rclass_ff;

   // sequencer and protocol state
   state_type   state_ff, state_in;
   phase_type   phase_ff, phase_in;
   logic [8:0]  air_time_ff, air_time_in;
   ticks_type   window_ff, window_in;
   ticks_type   first_window_ff, first_window_in;
   ticks_type   time_left_ff, time_left_in;
   logic [4:0]  halving_ff, halving_in;
   timer_type   sense_start_ff, sense_start_in;
   timer_type   elapsed_ff, elapsed_in;
   ticks_type   off_ff, off_in;
   logic        retry_ff, retry_in;
   logic        mul_ff, mul_in;

   // latched request
   command_type cmd_ff, cmd_in;
   ticks_type   budget_ff, budget_in;
   length_type  flen_ff, flen_in;
   dbm_type     rssi_ff, rssi_in;
   timer_type   now_ff, now_in;
   random_type  rnd_ff, rnd_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   action_type  action_ff, action_in;
   ticks_type   delay_ff, delay_in;
   logic        busy_ff, busy_in;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic             req_fire;
   logic             start_ok;
   logic             in_cca;
   logic             clear;
   logic             busy_sense;
   logic [8:0]       air_q;
   logic             air_fail;
   logic             guard_fail;
   logic             use_slots;
   logic             use_halving;
   logic [5:0]       shift_amt;
   logic [DIV_W-1:0] half_slot;
   logic [DIV_W-1:0] rate_w;
   logic [23:0]      product;

   csma_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_fire     = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.action      = action_ff;
   assign rsp_ch.delay_ticks = delay_ff;
   assign rsp_ch.busy_res    = busy_ff;

   // decode helpers
   always_comb begin
      start_ok    = (cmd_ff == CMD_START) && (phase_ff == PH_IDLE);
      in_cca      = (phase_ff == PH_CCA1) || (phase_ff == PH_CCA2);
      clear       = (rssi_ff <= thr_ff);
      busy_sense  = (cmd_ff == CMD_RSSI) && in_cca && !clear;
      air_q       = {1'b0, div_rsp.quotient[7:0]} + 9'd1;
      air_fail    = (budget_ff <= 15'(air_q));
      guard_fail  = (({1'b0, elapsed_ff} + 33'(GUARD_TICKS)) > {18'd0, time_left_ff});
      use_slots   = (mode_ff == MODE_RANDOM) || ((mode_ff == MODE_FIXED) && retry_ff);
      use_halving = (mode_ff == MODE_HALVING);
      shift_amt   = {1'b0, halving_ff} + 6'd1;
      half_slot   = {1'b0, first_window_ff} >> shift_amt;
      product     = off_ff * air_time_ff;
      case (rclass_ff)
         RC_LOW:    rate_w = RATE_LOW;
         RC_NORMAL: rate_w = RATE_NORMAL;
         RC_HIGH:   rate_w = RATE_HIGH;
         default:   rate_w = RATE_NORMAL;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (start_ok) state_in = ST_AIR;
            else if (busy_sense) state_in = ST_BUSY;
            else state_in = ST_IDLE;
         end
         ST_AIR: begin
            if (div_rsp.done) state_in = air_fail ? ST_IDLE : ST_OFFSET;
         end
         ST_BUSY: begin
            state_in = guard_fail ? ST_IDLE : ST_OFFSET;
         end
         ST_OFFSET: begin
            if (use_slots && (air_time_ff != '0)) state_in = ST_SLOTS;
            else if (use_halving && (half_slot != '0)) state_in = ST_MOD;
            else state_in = ST_ARM;
         end
         ST_SLOTS: begin
            if (div_rsp.done) state_in = (div_rsp.quotient == '0) ? ST_ARM : ST_MOD;
         end
         ST_MOD: begin
            if (div_rsp.done) state_in = mul_ff ? ST_MUL : ST_ARM;
         end
         ST_MUL:  state_in = ST_ARM;
         ST_ARM:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      phase_in        = phase_ff;
      air_time_in     = air_time_ff;
      window_in       = window_ff;
      first_window_in = first_window_ff;
      time_left_in    = time_left_ff;
      halving_in      = halving_ff;
      sense_start_in  = sense_start_ff;
      elapsed_in      = elapsed_ff;
      off_in          = off_ff;
      retry_in        = retry_ff;
      mul_in          = mul_ff;
      cmd_in          = cmd_ff;
      budget_in       = budget_ff;
      flen_in         = flen_ff;
      rssi_in         = rssi_ff;
      now_in          = now_ff;
      rnd_in          = rnd_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ch.ready;
      action_in       = action_ff;
      delay_in        = delay_ff;
      busy_in         = busy_ff;
      div_req         = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in    = req_ch.command;
               budget_in = req_ch.time_budget;
               flen_in   = req_ch.frame_length;
               rssi_in   = req_ch.rssi_sample;
               now_in    = req_ch.timer_now;
               rnd_in    = req_ch.random_word;
            end
         end
         ST_EXEC: begin
            action_in = ACT_NONE;
            delay_in  = '0;
            if (start_ok) begin
               div_req.start    = 1'b1;
               div_req.dividend = {8'd0, flen_ff};
               div_req.divisor  = rate_w;
               retry_in         = 1'b0;
            end else if (busy_sense) begin
               elapsed_in = now_ff - sense_start_ff;
               retry_in   = 1'b1;
            end else begin
               if ((cmd_ff == CMD_RSSI) && in_cca) begin
                  if (phase_ff == PH_CCA1) begin
                     phase_in  = PH_CCA2;
                     action_in = ACT_WAIT;
                     delay_in  = CCA_GAP;
                  end else begin
                     phase_in  = PH_TX;
                     action_in = ACT_TX;
                  end
               end else if ((cmd_ff == CMD_FINISH) && (phase_ff == PH_TX)) begin
                  phase_in  = PH_IDLE;
                  action_in = ACT_DONE;
               end
               rsp_valid_in = 1'b1;
               busy_in      = (phase_in != PH_IDLE);
            end
         end
         ST_AIR: begin
            if (div_rsp.done) begin
               air_time_in    = air_q;
               sense_start_in = now_ff;
               window_in      = budget_ff - 15'(air_q);
               if (air_fail) begin
                  rsp_valid_in = 1'b1;
                  action_in    = ACT_FAIL;
                  delay_in     = '0;
                  busy_in      = 1'b0;
               end else if (use_halving) begin
                  halving_in      = '0;
                  first_window_in = budget_ff - 15'(air_q);
               end
            end
         end
         ST_BUSY: begin
            if (guard_fail) begin
               phase_in     = PH_IDLE;
               rsp_valid_in = 1'b1;
               action_in    = ACT_FAIL;
               delay_in     = '0;
               busy_in      = 1'b0;
            end else begin
               window_in      = time_left_ff - elapsed_ff[14:0];
               sense_start_in = now_ff;
               if (use_halving && (halving_ff != 5'd31)) halving_in = halving_ff + 5'd1;
            end
         end
         ST_OFFSET: begin
            off_in = '0;
            if (use_slots && (air_time_ff != '0)) begin
               div_req.start    = 1'b1;
               div_req.dividend = {1'b0, window_ff};
               div_req.divisor  = {7'd0, air_time_ff};
            end else if (use_halving && (half_slot != '0)) begin
               div_req.start    = 1'b1;
               div_req.dividend = rnd_ff;
               div_req.divisor  = half_slot;
               mul_in           = 1'b0;
            end
         end
         ST_SLOTS: begin
            if (div_rsp.done && (div_rsp.quotient != '0)) begin
               div_req.start    = 1'b1;
               div_req.dividend = rnd_ff;
               div_req.divisor  = div_rsp.quotient;
               mul_in           = 1'b1;
            end
         end
         ST_MOD: begin
            if (div_rsp.done) off_in = div_rsp.remainder[14:0];
         end
         ST_MUL: begin
            off_in = product[14:0];
         end
         ST_ARM: begin
            time_left_in = window_ff - off_ff;
            phase_in     = PH_CCA1;
            rsp_valid_in = 1'b1;
            action_in    = ACT_WAIT;
            delay_in     = off_ff;
            busy_in      = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff          <= THRESHOLD_RESET;
         mode_ff         <= MODE_UNCHECKED;
         rclass_ff       <= RC_NORMAL;
         state_ff        <= ST_IDLE;
         phase_ff        <= PH_IDLE;
         air_time_ff     <= '0;
         window_ff       <= '0;
         first_window_ff <= '0;
         time_left_ff    <= '0;
         halving_ff      <= '0;
         sense_start_ff  <= '0;
         retry_ff        <= 1'b0;
         mul_ff          <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_THRESHOLD: thr_ff    <= csr_wdata;
               REG_MODE:      mode_ff   <= csr_wdata[1:0];
               REG_RATE:      rclass_ff <= csr_wdata[1:0];
               default: begin
               end
            endcase
         end
         state_ff        <= state_in;
         phase_ff        <= phase_in;
         air_time_ff     <= air_time_in;
         window_ff       <= window_in;
         first_window_ff <= first_window_in;
         time_left_ff    <= time_left_in;
         halving_ff      <= halving_in;
         sense_start_ff  <= sense_start_in;
         retry_ff        <= retry_in;
         mul_ff          <= mul_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      elapsed_ff <= elapsed_in;
      off_ff     <= off_in;
      cmd_ff     <= cmd_in;
      budget_ff  <= budget_in;
      flen_ff    <= flen_in;
      rssi_ff    <= rssi_in;
      now_ff     <= now_in;
      rnd_ff     <= rnd_in;
      action_ff  <= action_in;
      delay_ff   <= delay_in;
      busy_ff    <= busy_in;
   end

   `CSMA_ASSERT(a_div_start_free, div_req.start |-> !div_rsp.busy, "divider restarted while busy")
   `CSMA_ASSERT(a_fire_exec, req_fire |=> (state_ff == ST_EXEC), "accepted transfer not decoded")
   `CSMA_ASSERT(a_wait_busy, (rsp_valid_ff && (action_ff == ACT_WAIT)) |-> busy_ff, "wait response without busy")
   `CSMA_ASSERT_RST(a_reset_clean, reset |=> (!rsp_valid_ff && (state_ff == ST_IDLE)), "reset left work pending")

endmodule

`default_nettype wire
